>>> rtl/nde_pkg.sv
// ----------------------------------------------------------------------------
// nde_pkg
// Shared types and constants for the nonlinear diffusion step block.
// ----------------------------------------------------------------------------
package nde_pkg;

   localparam int unsigned DATA_W = 32;
   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] REG_COURANT = 2'd0;
   localparam logic [1:0] REG_COEF_POW = 2'd1;
   localparam logic [1:0] REG_BND_POW = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] step_size;
   } rsp_type;

   // one multiply job handed to the shared multiplier
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } mul_op_type;

   function automatic logic [31:0] sat_q16(input logic [63:0] p);
      logic [47:0] s;
      begin
         s = p[63:16];
         sat_q16 = (s[47:32] != 16'd0) ? SAT32 : s[31:0];
      end
   endfunction

endpackage

>>> rtl/nonlinear_diffusion_explicit_step.sv
// ----------------------------------------------------------------------------
// nonlinear_diffusion_explicit_step
// Explicit step of a 1D nonlinear heat equation on a rotating chain of cells.
// Step: raises time to boundary_power, then runs the coefficient sweep, the
// reciprocal divider and the update sweep.
// Read: one rotation of the chain. One item at a time.
// Synchronous reset clears the profile, time and step size; busy is low after.
// ----------------------------------------------------------------------------
module nonlinear_diffusion_explicit_step
   import nde_pkg::*;
#(
   parameter int CELLS = 1024
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NODES = CELLS + 1;
   localparam int CW = $clog2(NODES + 1);
   localparam int EW = $clog2(CELLS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BND = 4'd1;
   localparam logic [3:0] S_COEF = 4'd2;
   localparam logic [3:0] S_DIV = 4'd3;
   localparam logic [3:0] S_TAU = 4'd4;
   localparam logic [3:0] S_UPD = 4'd5;
   localparam logic [3:0] S_READ = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;

   // ---------------- configuration ----------------
   logic [15:0] cf_ff;
   logic [1:0]  cp_ff;
   logic [2:0]  bp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff <= 16'd19661;
         cp_ff <= 2'd1;
         bp_ff <= 3'd3;
      end else if (csr_valid) begin
         case (csr_index)
            REG_COURANT:  cf_ff <= csr_data[15:0];
            REG_COEF_POW: cp_ff <= csr_data[1:0];
            REG_BND_POW:  bp_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // ---------------- chain of cells ----------------
   // rotating: head (index 0) leaves, feed enters at the tail
   logic        shift;
   logic [31:0] feed;
   logic [31:0] nodes [NODES];

   for (genvar g = 0; g < NODES; g++) begin : g_chain
      logic [31:0] rin;
      if (g == NODES - 1) begin : g_tail
         assign rin = feed;
      end else begin : g_mid
         assign rin = nodes[g + 1];
      end
      nde_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .from_right (rin),
         .node       (nodes[g])
      );
   end

   // ---------------- shared multiplier ----------------
   mul_op_type  mop;
   logic [31:0] mres;

   nde_qmul u_mul (
      .clock (clock),
      .op    (mop),
      .prod  (mres)
   );

   // ---------------- divider ----------------
   logic        div_go;
   logic        div_done;
   logic [31:0] div_q;
   logic [31:0] kmax_ff;

   nde_recip u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .divisor  (kmax_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- coefficient memory ----------------
   logic [31:0] kmem [CELLS];
   logic        kwe;
   logic [EW-1:0] kwa, kra;
   logic [31:0] kwd, krd_ff;

   always_ff @(posedge clock) begin
      if (kwe) begin
         kmem[kwa] <= kwd;
      end
      krd_ff <= kmem[kra];
   end

   // ---------------- control ----------------
   logic [3:0]    st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [3:0]    sub_ff, sub_in;
   logic [31:0]   time_ff, time_in;
   logic [31:0]   last_ff, last_in;
   logic [31:0]   tau_ff, tau_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   prev_ff, prev_in;
   logic [31:0]   gl_ff, gl_in;
   logic [31:0]   gr_ff, gr_in;
   logic [33:0]   pos_ff, pos_in;
   logic [33:0]   neg_ff, neg_in;
   logic [31:0]   pw_ff, pw_in;
   logic [2:0]    pe_ff, pe_in;
   logic [31:0]   kmax_in;
   logic [10:0]   idx_ff, idx_in;
   logic          rd_ff, rd_in;
   logic [31:0]   out_ff, out_in;
   logic          strobe_ff, strobe_in;
   logic [31:0]   avg;
   logic [32:0]   tsum;

   assign busy = (st_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data.value = out_ff;
   assign rsp_data.step_size = last_ff;

   assign avg = (prev_ff >> 1) + (nodes[0] >> 1) + {31'd0, prev_ff[0] & nodes[0][0]};
   assign tsum = {1'b0, time_ff} + {1'b0, tau_ff};

   // sub_ff sequences each cell's multiplies through the pipelined multiplier:
   // each product passes its partial-product and output registers before it is read.
   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      sub_in = sub_ff;
      time_in = time_ff;
      last_in = last_ff;
      tau_in = tau_ff;
      acc_in = acc_ff;
      prev_in = prev_ff;
      gl_in = gl_ff;
      gr_in = gr_ff;
      pos_in = pos_ff;
      neg_in = neg_ff;
      pw_in = pw_ff;
      pe_in = pe_ff;
      kmax_in = kmax_ff;
      idx_in = idx_ff;
      rd_in = rd_ff;
      out_in = out_ff;
      strobe_in = 1'b0;
      shift = 1'b0;
      feed = nodes[0];
      mop.a = pw_ff;
      mop.b = acc_ff;
      div_go = 1'b0;
      kwe = 1'b0;
      kwa = cnt_ff[EW-1:0];
      kwd = mres;
      kra = cnt_ff[EW-1:0];

      case (st_ff)
         S_IDLE: begin
            if (start) begin
               cnt_in = '0;
               sub_in = '0;
               if (req_data.operation == OP_READ) begin
                  st_in = S_READ;
                  idx_in = req_data.cell_index;
                  rd_in = 1'b0;
                  out_in = '0;
               end else begin
                  st_in = S_BND;
                  pw_in = ONE_Q16;
                  acc_in = time_ff;
                  pe_in = '0;
               end
            end
         end

         // time^boundary_power by repeated multiply
         S_BND: begin
            mop.a = pw_ff;
            mop.b = acc_ff;
            sub_in = sub_ff + 4'd1;
            if (pe_ff == bp_ff) begin
               // the coefficient sweep rotates once, placing boundary at head, zero at tail
               // head will be written during the coefficient sweep
               st_in = S_COEF;
               cnt_in = '0;
               sub_in = '0;
               kmax_in = '0;
            end else if (sub_ff == 4'd2) begin
               pw_in = mres;
               pe_in = pe_ff + 3'd1;
               sub_in = '0;
            end
         end

         // sweep: node i at head; edge i-1 from prev and head
         S_COEF: begin
            case (sub_ff)
               4'd0: begin
                  if (cnt_ff == CW'(NODES)) begin
                     st_in = S_DIV;
                     div_go = (kmax_ff != 32'd0);
                     sub_in = '0;
                  end else begin
                     if (cnt_ff == '0) begin
                        feed = pw_ff;
                     end else if (cnt_ff == CW'(NODES - 1)) begin
                        feed = 32'd0;
                     end
                     if (cnt_ff == '0) begin
                        prev_in = pw_ff;
                        shift = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        acc_in = avg;
                        pw_in = ONE_Q16;
                        pe_in = '0;
                        sub_in = 4'd1;
                     end
                  end
               end
               default: begin
                  mop.a = pw_ff;
                  mop.b = acc_ff;
                  if (pe_ff == {1'b0, cp_ff}) begin
                     kwe = 1'b1;
                     kwa = EW'(cnt_ff - CW'(1));
                     kwd = pw_ff;
                     if (pw_ff > kmax_ff) begin
                        kmax_in = pw_ff;
                     end
                     prev_in = (cnt_ff == CW'(NODES - 1)) ? 32'd0 : nodes[0];
                     feed = (cnt_ff == CW'(NODES - 1)) ? 32'd0 : nodes[0];
                     shift = 1'b1;
                     cnt_in = cnt_ff + CW'(1);
                     sub_in = '0;
                  end else if (sub_ff == 4'd3) begin
                     pw_in = mres;
                     pe_in = pe_ff + 3'd1;
                     sub_in = 4'd1;
                  end else begin
                     sub_in = sub_ff + 4'd1;
                  end
               end
            endcase
         end

         S_DIV: begin
            if (kmax_ff == 32'd0) begin
               tau_in = ONE_Q16;
               st_in = S_UPD;
               cnt_in = '0;
               sub_in = '0;
            end else if (div_done) begin
               mop.a = {16'd0, cf_ff};
               mop.b = div_q;
               st_in = S_TAU;
               sub_in = '0;
            end
         end

         S_TAU: begin
            mop.a = {16'd0, cf_ff};
            mop.b = div_q;
            sub_in = sub_ff + 4'd1;
            if (sub_ff == 4'd1) begin
               tau_in = mres;
               st_in = S_UPD;
               cnt_in = '0;
               sub_in = '0;
            end
         end

         // update sweep: head is node i, nodes[1] is i+1, prev is old i-1
         S_UPD: begin
            kra = EW'(cnt_ff);
            if (cnt_ff == '0) begin
               prev_in = nodes[0];
               shift = 1'b1;
               feed = nodes[0];
               cnt_in = cnt_ff + CW'(1);
            end else if (cnt_ff == CW'(NODES - 1)) begin
               feed = 32'd0;
               shift = 1'b1;
               cnt_in = '0;
               tau_in = tau_ff;
               time_in = tsum[32] ? SAT32 : tsum[31:0];
               last_in = tau_ff;
               st_in = S_DONE;
            end else begin
               case (sub_ff)
                  4'd0: begin
                     kra = EW'(cnt_ff - CW'(1));
                     sub_in = 4'd1;
                  end
                  4'd1: begin
                     kra = EW'(cnt_ff);
                     mop.a = tau_ff;
                     mop.b = krd_ff;
                     sub_in = 4'd2;
                  end
                  4'd2: begin
                     mop.a = tau_ff;
                     mop.b = krd_ff;
                     sub_in = 4'd3;
                  end
                  4'd3: begin
                     gl_in = mres;
                     sub_in = 4'd4;
                  end
                  4'd4: begin
                     gr_in = mres;
                     mop.a = prev_ff;
                     mop.b = gl_ff;
                     sub_in = 4'd5;
                  end
                  4'd5: begin
                     mop.a = nodes[1];
                     mop.b = gr_ff;
                     sub_in = 4'd6;
                  end
                  4'd6: begin
                     pos_in = {2'b0, nodes[0]} + {2'b0, mres};
                     mop.a = nodes[0];
                     mop.b = gr_ff;
                     sub_in = 4'd7;
                  end
                  4'd7: begin
                     pos_in = pos_ff + {2'b0, mres};
                     mop.a = nodes[0];
                     mop.b = gl_ff;
                     sub_in = 4'd8;
                  end
                  4'd8: begin
                     neg_in = {2'b0, mres};
                     sub_in = 4'd9;
                  end
                  default: begin
                     neg_in = neg_ff + {2'b0, mres};
                     if (pos_ff > neg_in) begin
                        acc_in = ((pos_ff - neg_in) > 34'(SAT32)) ? SAT32
                                 : 32'(pos_ff - neg_in);
                     end else begin
                        acc_in = '0;
                     end
                     sub_in = 4'd10;
                     if (sub_ff == 4'd10) begin
                        prev_in = nodes[0];
                        feed = acc_ff;
                        shift = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                        sub_in = '0;
                        neg_in = neg_ff;
                        acc_in = acc_ff;
                     end
                  end
               endcase
            end
         end

         S_READ: begin
            if (cnt_ff == CW'(NODES)) begin
               st_in = S_DONE;
               time_in = time_ff;
            end else begin
               if (32'(idx_ff) == 32'(cnt_ff)) begin
                  out_in = nodes[0];
               end
               shift = 1'b1;
               feed = nodes[0];
               cnt_in = cnt_ff + CW'(1);
            end
         end

         S_DONE: begin
            if (rd_ff == 1'b0 && cnt_ff == CW'(NODES)) begin
               rd_in = 1'b1;
            end else begin
               out_in = time_ff;
            end
            if (cnt_ff == CW'(NODES)) begin
               out_in = out_ff;
            end
            strobe_in = 1'b1;
            st_in = S_IDLE;
         end

         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         cnt_ff <= '0;
         sub_ff <= '0;
         time_ff <= '0;
         last_ff <= '0;
         strobe_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
         time_ff <= time_in;
         last_ff <= last_in;
         strobe_ff <= strobe_in;
         rd_ff <= rd_in;
      end
      tau_ff <= tau_in;
      acc_ff <= acc_in;
      prev_ff <= prev_in;
      gl_ff <= gl_in;
      gr_ff <= gr_in;
      pos_ff <= pos_in;
      neg_ff <= neg_in;
      pw_ff <= pw_in;
      pe_ff <= pe_in;
      kmax_ff <= kmax_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

endmodule

>>> rtl/nde_qmul.sv
// ----------------------------------------------------------------------------
// nde_qmul
// Registered Q16.16 multiply, 64-bit product split into two 16x32 partial
// products accumulated over one pipeline, saturating.
// ----------------------------------------------------------------------------
module nde_qmul
   import nde_pkg::*;
(
   input  logic        clock,
   input  mul_op_type  op,
   output logic [31:0] prod
);

   logic [47:0] lo_ff, hi_ff;
   logic [47:0] lo_in, hi_in;
   logic [31:0] prod_ff, prod_in;
   logic [63:0] full;

   assign lo_in = 48'(op.a) * 48'(op.b[15:0]);
   assign hi_in = 48'(op.a) * 48'(op.b[31:16]);
   assign full = 64'(lo_ff) + {hi_ff, 16'd0};
   assign prod_in = sat_q16(full);
   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/nde_recip.sv
// ----------------------------------------------------------------------------
// nde_recip
// Radix-2 restoring divider for 2^32 / kmax, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nde_recip
   import nde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [32:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;

   // dividend is 1 followed by 32 zeros: 33 bit steps
   assign trial = {rem_ff, (cnt_ff == 6'd0)};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {2'b00, divisor}) begin
            rem_in = 33'(trial - {2'b00, divisor});
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff[32] ? SAT32 : quo_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

>>> rtl/nde_cell.sv
// ----------------------------------------------------------------------------
// nde_cell
// One node of the profile chain. Shifts toward lower index when enabled;
// cleared by reset.
// ----------------------------------------------------------------------------
module nde_cell
   import nde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        shift,
   input  logic [31:0] from_right,
   output logic [31:0] node
);

   logic [31:0] node_ff;

   assign node = node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= '0;
      end else if (shift) begin
         node_ff <= from_right;
      end
   end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nonlinear_diffusion_explicit_step. Step and read
// transactions, directed then random, run over several register settings.
// A predictor keeps its own copy of the profile and checks every response.
// ----------------------------------------------------------------------------
module tb_top
   import nde_pkg::*;
();

   localparam int NCELL = 32;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   nonlinear_diffusion_explicit_step #(.CELLS(NCELL)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [31:0] heat [0:NCELL];
   logic [31:0] heat_nxt [0:NCELL];
   logic [31:0] edge_k [0:NCELL-1];
   logic [31:0] t_elapsed;
   logic [31:0] t_step;
   logic [15:0] courant;
   logic [1:0]  k_pow;
   logic [2:0]  bnd_pow;

   req_type req_pending_q[$];
   rsp_type rsp_expect_q[$];
   int      error_count;
   int      gap_left;
   bit      hold_off;
   bit      no_gaps;
   int      cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      begin
         p = ({32'd0, a} * {32'd0, b}) >> 16;
         return (p[63:32] != 32'd0) ? SAT32 : p[31:0];
      end
   endfunction

   function automatic logic [31:0] q_pow(logic [31:0] x, int e);
      logic [31:0] r;
      begin
         r = ONE_Q16;
         for (int n = 0; n < e; n++) r = q_mul(r, x);
         return r;
      end
   endfunction

   function automatic void advance_heat();
      logic [31:0] kmax, tau, a, b, avg, gr, gl;
      logic [63:0] recip, prod, pos, neg, v;
      begin
         kmax = 32'd0;
         heat[NCELL] = 32'd0;
         heat[0] = q_pow(t_elapsed, bnd_pow);
         for (int i = 0; i < NCELL; i++) begin
            a = heat[i];
            b = heat[i+1];
            avg = (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
            edge_k[i] = q_pow(avg, k_pow);
            if (edge_k[i] > kmax) kmax = edge_k[i];
         end
         if (kmax == 32'd0) begin
            tau = ONE_Q16;
         end else begin
            recip = 64'h1_0000_0000 / {32'd0, kmax};
            if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
            prod = {48'd0, courant} * recip;
            tau = prod[47:16];
         end
         for (int i = 1; i < NCELL; i++) begin
            gr = q_mul(tau, edge_k[i]);
            gl = q_mul(tau, edge_k[i-1]);
            pos = {32'd0, heat[i]} + q_mul(heat[i+1], gr) + q_mul(heat[i-1], gl);
            neg = {32'd0, q_mul(heat[i], gr)} + q_mul(heat[i], gl);
            v = (pos > neg) ? pos - neg : 64'd0;
            heat_nxt[i] = (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
         end
         for (int i = 1; i < NCELL; i++) heat[i] = heat_nxt[i];
         v = {32'd0, t_elapsed} + tau;
         t_elapsed = (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
         t_step = tau;
      end
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      begin
         if (r.operation == OP_STEP) begin
            advance_heat();
            o.value = t_elapsed;
         end else begin
            o.value = (r.cell_index <= NCELL) ? heat[r.cell_index] : 32'd0;
         end
         o.step_size = t_step;
         return o;
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      begin
         roll = $urandom_range(0, 19);
         if (no_gaps || roll < 11) return 0;
         if (roll < 18) return $urandom_range(1, 3);
         return $urandom_range(15, 60);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      logic    nxt_start;
      req_type nxt_req;
      nxt_start = start;
      nxt_req = req_data;
      if (reset) begin
         nxt_start = 1'b0;
         gap_left <= 0;
      end else if (!start || !busy) begin
         if (start) rsp_expect_q.push_back(predict_response(req_data));
         nxt_start = 1'b0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (req_pending_q.size() != 0 && !hold_off) begin
            nxt_req = req_pending_q.pop_front();
            nxt_start = 1'b1;
            gap_left <= pick_gap();
         end
      end
      start <= nxt_start;
      req_data <= nxt_req;
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (rsp_expect_q.size() == 0) begin
            $display("%0t: unexpected response value=%h step=%h", $time,
                     rsp_data.value, rsp_data.step_size);
            error_count++;
         end else begin
            exp_rsp = rsp_expect_q.pop_front();
            if (rsp_data.value !== exp_rsp.value) begin
               $display("%0t: value mismatch expected %h actual %h", $time,
                        exp_rsp.value, rsp_data.value);
               error_count++;
            end
            if (rsp_data.step_size !== exp_rsp.step_size) begin
               $display("%0t: step_size mismatch expected %h actual %h", $time,
                        exp_rsp.step_size, rsp_data.step_size);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      begin
         @(posedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= val;
         @(posedge clock);
         while (!(csr_valid && csr_ready)) @(posedge clock);
         case (idx)
            REG_COURANT: courant = val[15:0];
            REG_COEF_POW: k_pow = val[1:0];
            REG_BND_POW: bnd_pow = val[2:0];
            default: ;
         endcase
         csr_valid <= 1'b0;
      end
   endtask

   task automatic wait_idle();
      begin
         @(posedge clock);
         while (req_pending_q.size() != 0 || rsp_expect_q.size() != 0 || start)
            @(posedge clock);
         repeat (8) @(posedge clock);
         while (busy) @(posedge clock);
      end
   endtask

   task automatic push_req(logic op, logic [10:0] idx);
      req_type r;
      begin
         r.operation = op;
         r.cell_index = idx;
         req_pending_q.push_back(r);
      end
   endtask

   task automatic push_random(int n);
      int roll;
      begin
         for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 9);
            if (roll < 5) push_req(OP_STEP, 11'($urandom));
            else if (roll < 9) push_req(OP_READ, 11'($urandom_range(0, NCELL)));
            else push_req(OP_READ, 11'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      error_count = 0;
      hold_off = 1'b0;
      no_gaps = 1'b0;
      cycle_count = 0;
      for (int i = 0; i <= NCELL; i++) heat[i] = 32'd0;
      for (int i = 0; i < NCELL; i++) edge_k[i] = 32'd0;
      t_elapsed = 32'd0;
      t_step = 32'd0;
      courant = 16'd19661;
      k_pow = 2'd1;
      bnd_pow = 3'd3;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reads before any step, boundary indexes, first steps
      push_req(OP_READ, 11'd0);
      push_req(OP_READ, 11'(NCELL));
      push_req(OP_READ, 11'(NCELL + 1));
      push_req(OP_READ, 11'h7FF);
      for (int i = 0; i < 4; i++) push_req(OP_STEP, 11'h7FF);
      push_req(OP_READ, 11'd0);
      push_req(OP_READ, 11'd1);
      push_req(OP_READ, 11'(NCELL - 1));
      wait_idle();

      // extremes: full factor, high powers, saturating time
      csr_write(REG_COURANT, 32'h0000_FFFF);
      csr_write(REG_COEF_POW, 32'd3);
      csr_write(REG_BND_POW, 32'd4);
      for (int i = 0; i < 5; i++) push_req(OP_STEP, 11'd0);
      while (req_pending_q.size() != 0) @(posedge clock);
      // sender holds until every outstanding response is back
      hold_off = 1'b1;
      push_req(OP_READ, 11'd0);
      push_req(OP_READ, 11'd2);
      while (rsp_expect_q.size() != 0 || busy || start) @(posedge clock);
      hold_off = 1'b0;
      wait_idle();

      // zero factor, zero power, unusual boundary power
      csr_write(REG_COURANT, 32'd0);
      csr_write(REG_COEF_POW, 32'd0);
      csr_write(REG_BND_POW, 32'd7);
      push_req(OP_STEP, 11'd0);
      push_req(OP_READ, 11'd1);
      wait_idle();
      csr_write(REG_BND_POW, 32'd0);

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(REG_COURANT, 32'($urandom));
         csr_write(REG_COEF_POW, 32'($urandom_range(1, 3)));
         csr_write(REG_BND_POW, 32'($urandom_range(0, 4)));
         no_gaps = (ph % 3 == 1);
         push_random(17);
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0 && rsp_expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
